// File: sv/lfu_cache_lru_tiebreak_unit_assert.svh
// Assertion macros for the LFU cache block.
// Used by the port-level checker; expects signals clk and rst in scope.
`ifndef LFU_CACHE_LRU_TIEBREAK_UNIT_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_UNIT_ASSERT_SVH
// Same-cycle implication.
`define LFU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define LFU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/lfu_pkg.sv
// Shared types and constants for the LFU cache block.
// No dependencies.
package lfu_pkg;
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_BITS       = 5;
  localparam int DATA_W         = 32;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0]   GET_MISS  = '1;
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Update broadcast to all cells.
  typedef struct packed {
    logic en;     // apply an update this cycle
    logic fresh;  // install new key/value with count 1
    logic wr;     // overwrite value on hit
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_t;
endpackage

// File: sv/lfu_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on lfu_pkg.
interface lfu_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic signed [lfu_pkg::DATA_W-1:0] lookup_key;
  logic signed [lfu_pkg::DATA_W-1:0] store_value;
  modport source (output valid, req_type, lookup_key, store_value, input ready);
  modport sink (input valid, req_type, lookup_key, store_value, output ready);
endinterface

interface lfu_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic signed [lfu_pkg::DATA_W-1:0] read_value;
  logic evicted;
  modport source (output valid, found, read_value, evicted, input ready);
  modport sink (input valid, found, read_value, evicted, output ready);
endinterface

// File: sv/lfu_cache_lru_tiebreak_unit.sv
// LFU cache with LRU tie break: a row of ENTRIES slot cells through which a
// search token travels one slot per cycle, collecting the key match and the
// eviction candidate. One request at a time: accept, then scan and update
// while the token passes the whole cell row, then the response beat; a new
// request is accepted only once the response has been taken.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and lfu_cell.
module lfu_cache_lru_tiebreak_unit #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_data,
  lfu_req_if.sink                       req,
  lfu_rsp_if.source                     rsp
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = ((FW > lfu_pkg::CAP_BITS) ? FW : lfu_pkg::CAP_BITS) + 1;
  localparam int DW = lfu_pkg::DATA_W;

  lfu_pkg::state_t            state;
  logic [lfu_pkg::CAP_BITS-1:0] capacity;
  logic [FW-1:0]              fill;
  logic [FW-1:0]              cnt;
  logic                       is_put;
  logic [DW-1:0]              req_key;
  logic [DW-1:0]              req_val;

  logic                       c_hit      [ENTRIES+1];
  logic [IW-1:0]              c_hit_idx  [ENTRIES+1];
  logic [DW-1:0]              c_hit_val  [ENTRIES+1];
  logic [FW-1:0]              c_hit_rank [ENTRIES+1];
  logic                       c_best_vld [ENTRIES+1];
  logic [IW-1:0]              c_best_idx [ENTRIES+1];
  logic [COUNT_BITS-1:0]      c_best_cnt [ENTRIES+1];
  logic [FW-1:0]              c_best_rank[ENTRIES+1];

  lfu_pkg::upd_t              upd;
  logic [IW-1:0]              upd_idx;
  logic [FW-1:0]              upd_rank;
  logic                       done;
  logic                       has_room;
  logic [CW-1:0]              eff_cap;

  assign c_hit[0]       = 1'b0;
  assign c_hit_idx[0]   = '0;
  assign c_hit_val[0]   = '0;
  assign c_hit_rank[0]  = '0;
  assign c_best_vld[0]  = 1'b0;
  assign c_best_idx[0]  = '0;
  assign c_best_cnt[0]  = '0;
  assign c_best_rank[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .COUNT_BITS(COUNT_BITS), .IDX(g), .IW(IW), .FW(FW)
    ) u_cell (
      .clk          (clk),
      .req_key      (req_key),
      .req_val      (req_val),
      .fill         (fill),
      .upd          (upd),
      .upd_idx      (upd_idx),
      .upd_rank     (upd_rank),
      .in_hit       (c_hit[g]),
      .in_hit_idx   (c_hit_idx[g]),
      .in_hit_val   (c_hit_val[g]),
      .in_hit_rank  (c_hit_rank[g]),
      .in_best_vld  (c_best_vld[g]),
      .in_best_idx  (c_best_idx[g]),
      .in_best_cnt  (c_best_cnt[g]),
      .in_best_rank (c_best_rank[g]),
      .out_hit      (c_hit[g+1]),
      .out_hit_idx  (c_hit_idx[g+1]),
      .out_hit_val  (c_hit_val[g+1]),
      .out_hit_rank (c_hit_rank[g+1]),
      .out_best_vld (c_best_vld[g+1]),
      .out_best_idx (c_best_idx[g+1]),
      .out_best_cnt (c_best_cnt[g+1]),
      .out_best_rank(c_best_rank[g+1])
    );
  end

  assign req.ready = (state == lfu_pkg::ST_IDLE);
  assign rsp.valid = (state == lfu_pkg::ST_OUT);
  assign done      = (state == lfu_pkg::ST_SCAN) && (cnt == FW'(ENTRIES));

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(capacity) > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(capacity);
    end
  end
  assign has_room = CW'(fill) < eff_cap;

  // decide the update once the token has passed the last slot
  always_comb begin
    upd      = '0;
    upd_idx  = c_hit_idx[ENTRIES];
    upd_rank = c_hit_rank[ENTRIES];
    if (done) begin
      if (c_hit[ENTRIES]) begin
        upd.en = 1'b1;
        upd.wr = is_put;
      end else if (is_put) begin
        upd.en    = 1'b1;
        upd.fresh = 1'b1;
        if (has_room) begin
          upd_idx  = fill[IW-1:0];
          upd_rank = fill + FW'(1);
        end else begin
          upd_idx  = c_best_idx[ENTRIES];
          upd_rank = c_best_rank[ENTRIES];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lfu_pkg::ST_IDLE;
      capacity <= lfu_pkg::CAP_RESET;
      fill     <= '0;
      cnt      <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      unique case (state)
        lfu_pkg::ST_IDLE: begin
          cnt <= '0;
          if (req.valid) begin
            state <= lfu_pkg::ST_SCAN;
          end
        end
        lfu_pkg::ST_SCAN: begin
          cnt <= cnt + FW'(1);
          if (done) begin
            state <= lfu_pkg::ST_OUT;
            if (!c_hit[ENTRIES] && is_put && has_room) begin
              fill <= fill + FW'(1);
            end
          end
        end
        lfu_pkg::ST_OUT: begin
          if (rsp.ready) begin
            state <= lfu_pkg::ST_IDLE;
          end
        end
        default: state <= lfu_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      is_put  <= (req.req_type == lfu_pkg::REQ_PUT);
      req_key <= req.lookup_key;
      req_val <= req.store_value;
    end
    if (done) begin
      rsp.found   <= c_hit[ENTRIES];
      rsp.evicted <= !c_hit[ENTRIES] && is_put && !has_room;
      if (is_put) begin
        rsp.read_value <= '0;
      end else if (c_hit[ENTRIES]) begin
        rsp.read_value <= c_hit_val[ENTRIES];
      end else begin
        rsp.read_value <= lfu_pkg::GET_MISS;
      end
    end
  end
endmodule

// File: sv/lfu_cell.sv
// One cache slot: key, value, use count and recency rank, plus one stage of
// the search token that walks the row. Depends on lfu_pkg.
module lfu_cell #(
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int IDX        = 0,
  parameter int IW         = 1,
  parameter int FW         = 1
) (
  input  logic                          clk,
  input  logic [lfu_pkg::DATA_W-1:0]    req_key,
  input  logic [lfu_pkg::DATA_W-1:0]    req_val,
  input  logic [FW-1:0]                 fill,
  input  lfu_pkg::upd_t                 upd,
  input  logic [IW-1:0]                 upd_idx,
  input  logic [FW-1:0]                 upd_rank,
  input  logic                          in_hit,
  input  logic [IW-1:0]                 in_hit_idx,
  input  logic [lfu_pkg::DATA_W-1:0]    in_hit_val,
  input  logic [FW-1:0]                 in_hit_rank,
  input  logic                          in_best_vld,
  input  logic [IW-1:0]                 in_best_idx,
  input  logic [COUNT_BITS-1:0]         in_best_cnt,
  input  logic [FW-1:0]                 in_best_rank,
  output logic                          out_hit,
  output logic [IW-1:0]                 out_hit_idx,
  output logic [lfu_pkg::DATA_W-1:0]    out_hit_val,
  output logic [FW-1:0]                 out_hit_rank,
  output logic                          out_best_vld,
  output logic [IW-1:0]                 out_best_idx,
  output logic [COUNT_BITS-1:0]         out_best_cnt,
  output logic [FW-1:0]                 out_best_rank
);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [lfu_pkg::DATA_W-1:0] key;
  logic [lfu_pkg::DATA_W-1:0] val;
  logic [COUNT_BITS-1:0]      cnt;
  logic [FW-1:0]              rank;
  logic                       used;
  logic                       mine;
  logic                       better;

  assign used   = FW'(IDX) < fill;
  assign mine   = used && (key == req_key);
  assign better = used && (!in_best_vld || (cnt < in_best_cnt) ||
                           ((cnt == in_best_cnt) && (rank > in_best_rank)));

  // advance the search token one slot
  always_ff @(posedge clk) begin
    out_hit <= in_hit | mine;
    if (!in_hit && mine) begin
      out_hit_idx  <= MY_IDX;
      out_hit_val  <= val;
      out_hit_rank <= rank;
    end else begin
      out_hit_idx  <= in_hit_idx;
      out_hit_val  <= in_hit_val;
      out_hit_rank <= in_hit_rank;
    end
    out_best_vld <= in_best_vld | used;
    if (better) begin
      out_best_idx  <= MY_IDX;
      out_best_cnt  <= cnt;
      out_best_rank <= rank;
    end else begin
      out_best_idx  <= in_best_idx;
      out_best_cnt  <= in_best_cnt;
      out_best_rank <= in_best_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      if (upd_idx == MY_IDX) begin
        rank <= '0;
        if (upd.fresh) begin
          key <= req_key;
          val <= req_val;
          cnt <= COUNT_BITS'(1);
        end else begin
          if (cnt != '1) begin
            cnt <= cnt + COUNT_BITS'(1);
          end
          if (upd.wr) begin
            val <= req_val;
          end
        end
      end else if (used && (rank < upd_rank)) begin
        rank <= rank + FW'(1);
      end
    end
  end
endmodule

// File: sv/lfu_chk.sv
// Port-level checker for the LFU cache block, bound to the top level.
// Depends on lfu_cache_lru_tiebreak_unit_assert.svh.
`include "lfu_cache_lru_tiebreak_unit_assert.svh"
module lfu_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_found,
  input logic        rsp_evicted,
  input logic [31:0] rsp_read_value
);
  logic req_acc;

  assign req_acc = req_valid && req_ready;

  // one request in flight: no new beat while a response waits
  `LFU_ASSERT_IMP(a_one_in_flight, rsp_valid, !req_ready, "request taken while response pending")
  `LFU_ASSERT_IMP(a_evict_miss, rsp_valid && rsp_evicted, !rsp_found, "eviction on a hit")
  `LFU_ASSERT_NXT(a_busy_after_accept, req_acc, !req_ready && !rsp_valid, "no scan after accept")
  `LFU_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value), "response beat dropped")
endmodule

bind lfu_cache_lru_tiebreak_unit lfu_chk u_lfu_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_found     (rsp.found),
  .rsp_evicted   (rsp.evicted),
  .rsp_read_value(rsp.read_value)
);

// File: sim/lfu_checker.sv
// Checker for the LFU cache block: watches the request and response channels,
// predicts each response from its own cache copy and compares field by field.
// Depends on lfu_pkg and the lfu_req_if/lfu_rsp_if interfaces.
module lfu_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_data,
  lfu_req_if.sink          req,
  lfu_rsp_if.sink          rsp,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = lfu_pkg::ENTRIES_DEF;
  localparam int CW    = lfu_pkg::COUNT_BITS_DEF;
  localparam int DW    = lfu_pkg::DATA_W;
  localparam logic [CW-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic          found;
    logic [DW-1:0] read_value;
    logic          evicted;
  } lookup_result_t;

  logic [4:0]        capacity_reg;
  int                fill;
  logic [DW-1:0]     slot_key [NSLOT];
  logic [DW-1:0]     slot_val [NSLOT];
  logic [CW-1:0]     slot_uses [NSLOT];
  int                slot_age [NSLOT];
  lookup_result_t    expected_q [$];

  assign pending = expected_q.size();

  function automatic void promote(int s, int old_age);
    for (int i = 0; i < fill; i++)
      if (i != s && slot_age[i] < old_age) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic lookup_result_t cache_access(logic is_put, logic [DW-1:0] k,
                                                  logic [DW-1:0] v);
    lookup_result_t r;
    int s;
    int lim;
    bit hit;
    r = '0;
    s = 0;
    hit = 0;
    for (int i = 0; i < fill; i++)
      if (!hit && slot_key[i] == k) begin
        s = i;
        hit = 1;
      end
    r.found = hit;
    if (hit) begin
      if (slot_uses[s] != COUNT_TOP) slot_uses[s]++;
      promote(s, slot_age[s]);
      if (is_put == lfu_pkg::REQ_PUT) slot_val[s] = v;
      else r.read_value = slot_val[s];
      return r;
    end
    if (is_put == lfu_pkg::REQ_GET) begin
      r.read_value = lfu_pkg::GET_MISS;
      return r;
    end
    lim = (capacity_reg == 0) ? 1 : (capacity_reg > NSLOT ? NSLOT : int'(capacity_reg));
    if (fill < lim) begin
      s = fill;
      fill++;
      promote(s, fill);
    end else begin
      s = 0;
      for (int i = 1; i < fill; i++)
        if (slot_uses[i] < slot_uses[s] ||
            (slot_uses[i] == slot_uses[s] && slot_age[i] > slot_age[s])) s = i;
      promote(s, slot_age[s]);
      r.evicted = 1'b1;
    end
    slot_key[s] = k;
    slot_val[s] = v;
    slot_uses[s] = CW'(1);
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst) begin
      capacity_reg <= lfu_pkg::CAP_RESET;
      fill = 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) capacity_reg <= cfg_data;
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("ERROR: response beat with nothing expected");
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.found !== rsp.found || exp_r.read_value !== rsp.read_value ||
              exp_r.evicted !== rsp.evicted) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("ERROR: exp found=%0b value=%h evicted=%0b got %0b %h %0b",
                       exp_r.found, exp_r.read_value, exp_r.evicted,
                       rsp.found, rsp.read_value, rsp.evicted);
          end
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(cache_access(req.req_type, req.lookup_key, req.store_value));
    end
  end
endmodule

// File: sim/tb_top.sv
// Top of the LFU cache testbench: clock, reset, capacity writes, request and
// response pacing, verdict. Depends on lfu_pkg, the interfaces, lfu_checker and the DUT.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 400000;
  localparam int DW = lfu_pkg::DATA_W;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic [4:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  bit         hold_rsp = 0;
  logic [DW-1:0] key_pool [8];

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  lfu_cache_lru_tiebreak_unit dut (.clk(clk), .rst(rst), .cfg_we(cfg_we),
                                   .cfg_data(cfg_data), .req(req), .rsp(rsp));
  lfu_checker chk (.clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
                   .req(req), .rsp(rsp), .fail_count(fail_count), .pending(pending));

  always #5 clk = ~clk;

  initial begin
    req.valid = 0;
    req.req_type = lfu_pkg::REQ_GET;
    req.lookup_key = '0;
    req.store_value = '0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, mostly short, with a long hold-off on request.
  always @(posedge clk) begin
    int r;
    if (rst || hold_rsp) rsp.ready <= 0;
    else begin
      r = $urandom_range(0, 99);
      if (r < 55) rsp.ready <= 1;
      else if (r < 97) rsp.ready <= 0;
      else begin
        rsp.ready <= 0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Keep valid high across a zero gap; the next send or drain sets it.
  task automatic send(logic t, logic [DW-1:0] k, logic [DW-1:0] v);
    int gap;
    req.valid <= 1;
    req.req_type <= t;
    req.lookup_key <= k;
    req.store_value <= v;
    do @(posedge clk); while (!req.ready);
    gap = gap_len();
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] c);
    cfg_we <= 1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Mostly keys from a small pool so hits, count growth and evictions occur.
  function automatic logic [DW-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  initial begin
    logic [4:0] caps [6] = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd7};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extreme keys and values, get miss, put fill, hit, update.
    send(lfu_pkg::REQ_GET, 32'h8000_0000, 32'h0);
    send(lfu_pkg::REQ_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send(lfu_pkg::REQ_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send(lfu_pkg::REQ_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send(lfu_pkg::REQ_PUT, 32'h0, 32'h0);
    send(lfu_pkg::REQ_GET, 32'h8000_0000, 32'h1234_5678);
    send(lfu_pkg::REQ_GET, 32'h7fff_ffff, 32'h0);
    send(lfu_pkg::REQ_PUT, 32'h7fff_ffff, 32'h5555_aaaa);
    send(lfu_pkg::REQ_GET, 32'h7fff_ffff, 32'h0);
    send(lfu_pkg::REQ_GET, 32'h1, 32'h0);
    drain();
    // Lower capacity below the fill: every put miss evicts.
    write_capacity(5'd2);
    send(lfu_pkg::REQ_PUT, 32'haaaa_5555, 32'h1);
    send(lfu_pkg::REQ_PUT, 32'h5555_aaaa, 32'h2);
    send(lfu_pkg::REQ_GET, 32'h0, 32'h0);
    send(lfu_pkg::REQ_PUT, 32'h0, 32'h3);
    drain();
    // Long receiver hold-off while requests keep coming.
    hold_rsp = 1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_rsp = 0;
      end
      for (int i = 0; i < 6; i++) send(lfu_pkg::REQ_PUT, 32'h100 + i, i);
    join
    drain();
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      foreach (key_pool[i]) key_pool[i] = $urandom();
      key_pool[0] = 32'h8000_0000;
      for (int n = 0; n < 290; n++)
        send(1'($urandom_range(0, 1)), pick_key(), $urandom());
      drain();
    end
    // Repeated hits on one key, then an update and a read back.
    write_capacity(5'd16);
    send(lfu_pkg::REQ_PUT, 32'hc0de, 32'h1);
    send(lfu_pkg::REQ_GET, 32'hc0de, 32'h0);
    send(lfu_pkg::REQ_PUT, 32'hc0de, 32'h2);
    send(lfu_pkg::REQ_GET, 32'hc0de, 32'h0);
    drain();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: lfu_cache_lru_tiebreak_unit.f
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_if.sv
sv/lfu_cell.sv
sv/lfu_cache_lru_tiebreak_unit.sv
sv/lfu_chk.sv
sim/lfu_checker.sv
sim/tb_top.sv
